// ===== rtl/mtskdv_pkg.sv =====
package mtskdv_pkg;

  localparam int KEY_W  = 64;
  localparam int SEQ_W  = 56;
  localparam int KIND_W = 8;
  localparam int SNAP_W = 64;

  // type byte codes
  localparam logic [KIND_W-1:0] KIND_DELETION = 8'h00;

  // next_side code when the merge is complete
  localparam logic [1:0] SIDE_NONE = 2'd2;

  // side status bit positions
  localparam int ST_HELD0 = 0;
  localparam int ST_HELD1 = 1;
  localparam int ST_END0  = 2;
  localparam int ST_END1  = 3;

  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
  localparam logic [SEQ_W-1:0] SEQ_ONES = {SEQ_W{1'b1}};

  // one chosen head (or the final marker) handed from front to back
  typedef struct packed {
    logic              side;
    logic              fin;
    logic [KEY_W-1:0]  key;
    logic [SEQ_W-1:0]  seq;
    logic [KIND_W-1:0] kind;
  } cmd_t;

endpackage

// ===== rtl/merge_two_sorted_keys_drop_versions.sv =====
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    source_port, item_key, item_seq, item_kind
// out       output     out_valid / out_ready  from_side, discard, finished, key, seq, kind,
//                                             next_side
// cfg       input      cfg_wr_en              cfg_wr_data (oldest_snapshot)
//
// one request per cycle sustained while the command queue has room; a request that causes a result shows it on out
// after the front stage and queue, then the output register
// the front accepts whenever the command queue has room, so in_ready falls only
// after QUEUE_DEPTH results back up behind a stalled out_ready
// synchronous active-low reset; no clearing pass, the block is ready right after reset
module merge_two_sorted_keys_drop_versions #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_source_port,
  input  logic [63:0] in_item_key,
  input  logic [55:0] in_item_seq,
  input  logic [7:0]  in_item_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_from_side,
  output logic        out_discard,
  output logic        out_finished,
  output logic [63:0] out_key,
  output logic [55:0] out_seq,
  output logic [7:0]  out_kind,
  output logic [1:0]  out_next_side
);
  import mtskdv_pkg::*;

  // snapshot floor, to be written by the user only while the block is idle; the block itself does not enforce this
  logic [SNAP_W-1:0] oldest_snapshot_r;

  // front to queue
  logic q_full, q_push;
  cmd_t q_push_data;
  // queue to back
  logic q_pop, q_valid;
  cmd_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_snapshot_r <= '0;
    end else if (cfg_wr_en) begin
      oldest_snapshot_r <= cfg_wr_data;
    end
  end

  // front: filters requests for sides not needed, holds the two heads and
  // picks the smaller internal key as soon as both sides are resolved
  mtskdv_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_source_port (in_source_port),
    .in_item_key    (in_item_key),
    .in_item_seq    (in_item_seq),
    .in_item_kind   (in_item_kind),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_push_data    (q_push_data)
  );

  // short command queue so the front keeps going while out is stalled
  mtskdv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  // back: version run tracking, drop decision and output register
  mtskdv_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .oldest_snapshot (oldest_snapshot_r),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_from_side   (out_from_side),
    .out_discard     (out_discard),
    .out_finished    (out_finished),
    .out_key         (out_key),
    .out_seq         (out_seq),
    .out_kind        (out_kind),
    .out_next_side   (out_next_side)
  );

  // nothing follows the final result once it has been taken
  a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_finished |=> !out_valid)
    else $error("result after final marker");

  // next_side is the none code exactly on the final result
  a_next_side_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_finished == (out_next_side == SIDE_NONE)))
    else $error("next_side inconsistent with finished");

  // final result carries an empty entry and is never dropped
  a_final_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> !out_discard && out_key == '0 && out_seq == '0)
    else $error("final result not empty");

endmodule

// ===== rtl/mtskdv_front.sv =====
module mtskdv_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_source_port,
  input  logic [63:0]               in_item_key,
  input  logic [55:0]               in_item_seq,
  input  logic [7:0]                in_item_kind,
  input  logic                      q_full,
  output logic                      q_push,
  output mtskdv_pkg::cmd_t          q_push_data
);
  import mtskdv_pkg::*;

  logic [3:0]        st_r, st_nxt, st_a;
  logic              done_r, done_nxt;
  logic [KEY_W-1:0]  head0_key_r, head1_key_r, h0k, h1k;
  logic [SEQ_W-1:0]  head0_seq_r, head1_seq_r, h0s, h1s;
  logic [KIND_W-1:0] head0_kind_r, head1_kind_r, h0t, h1t;
  logic              side, is_end, blocked, take, wr0, wr1;
  logic              have0, have1, resolved, pick;
  cmd_t              cmd;

  assign in_ready = ~q_full;

  always_comb begin
    side    = in_source_port;
    is_end  = (in_item_key == '0) && (in_item_seq == '0) && (in_item_kind == '0);
    blocked = done_r | (side ? (st_r[ST_HELD1] | st_r[ST_END1])
                             : (st_r[ST_HELD0] | st_r[ST_END0]));
    take    = in_valid & in_ready & ~blocked;
    wr0     = take & ~side & ~is_end;
    wr1     = take & side & ~is_end;

    st_a = st_r;
    if (take) begin
      if (is_end) begin
        if (side) st_a[ST_END1] = 1'b1;
        else      st_a[ST_END0] = 1'b1;
      end else begin
        if (side) st_a[ST_HELD1] = 1'b1;
        else      st_a[ST_HELD0] = 1'b1;
      end
    end

    // heads as they stand after this item
    h0k = wr0 ? in_item_key  : head0_key_r;
    h0s = wr0 ? in_item_seq  : head0_seq_r;
    h0t = wr0 ? in_item_kind : head0_kind_r;
    h1k = wr1 ? in_item_key  : head1_key_r;
    h1s = wr1 ? in_item_seq  : head1_seq_r;
    h1t = wr1 ? in_item_kind : head1_kind_r;

    have0    = st_a[ST_HELD0];
    have1    = st_a[ST_HELD1];
    resolved = (st_a[ST_HELD0] | st_a[ST_END0]) & (st_a[ST_HELD1] | st_a[ST_END1]);

    if (have0 && have1) begin
      if (h0k < h1k)      pick = 1'b0;
      else if (h0k > h1k) pick = 1'b1;
      else                pick = (h0s >= h1s) ? 1'b0 : 1'b1;
    end else begin
      pick = ~have0;
    end

    q_push   = take & resolved;
    st_nxt   = st_a;
    done_nxt = done_r;
    cmd      = '0;
    if (q_push) begin
      if (!have0 && !have1) begin
        done_nxt = 1'b1;
        cmd.fin  = 1'b1;
      end else if (pick) begin
        st_nxt[ST_HELD1] = 1'b0;
        cmd.side = 1'b1;
        cmd.key  = h1k;
        cmd.seq  = h1s;
        cmd.kind = h1t;
      end else begin
        st_nxt[ST_HELD0] = 1'b0;
        cmd.key  = h0k;
        cmd.seq  = h0s;
        cmd.kind = h0t;
      end
    end
    q_push_data = cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr0) begin
      head0_key_r  <= in_item_key;
      head0_seq_r  <= in_item_seq;
      head0_kind_r <= in_item_kind;
    end
    if (wr1) begin
      head1_key_r  <= in_item_key;
      head1_seq_r  <= in_item_seq;
      head1_kind_r <= in_item_kind;
    end
  end

endmodule

// ===== rtl/mtskdv_queue.sv =====
module mtskdv_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mtskdv_pkg::cmd_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output mtskdv_pkg::cmd_t pop_data
);
  import mtskdv_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_pop    = pop & pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/mtskdv_back.sv =====
module mtskdv_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [63:0]      oldest_snapshot,
  input  logic             q_valid,
  input  mtskdv_pkg::cmd_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_from_side,
  output logic             out_discard,
  output logic             out_finished,
  output logic [63:0]      out_key,
  output logic [55:0]      out_seq,
  output logic [7:0]       out_kind,
  output logic [1:0]       out_next_side
);
  import mtskdv_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  logic             side_r, discard_r, fin_r;
  logic [KEY_W-1:0] key_r, run_key_r;
  logic [SEQ_W-1:0] seq_r, run_last_seq_r, last_seq;
  logic [KIND_W-1:0] kind_r;
  logic [1:0]       next_r;
  logic             drop;

  assign q_pop = q_valid & (~out_valid_r | out_ready);

  always_comb begin
    // a new user key restarts the version run
    last_seq = (q_data.key != run_key_r) ? SEQ_ONES : run_last_seq_r;
    drop = ({{(SNAP_W-SEQ_W){1'b0}}, last_seq} <= oldest_snapshot) ||
           ((q_data.kind == KIND_DELETION) &&
            ({{(SNAP_W-SEQ_W){1'b0}}, q_data.seq} <= oldest_snapshot));
    out_valid_nxt = out_valid_r;
    if (q_pop)                     out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      run_key_r      <= KEY_ONES;
      run_last_seq_r <= SEQ_ONES;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop && !q_data.fin) begin
        run_key_r      <= q_data.key;
        run_last_seq_r <= q_data.seq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      side_r    <= q_data.side;
      fin_r     <= q_data.fin;
      discard_r <= ~q_data.fin & drop;
      key_r     <= q_data.key;
      seq_r     <= q_data.seq;
      kind_r    <= q_data.kind;
      next_r    <= q_data.fin ? SIDE_NONE : {1'b0, q_data.side};
    end
  end

  assign out_valid     = out_valid_r;
  assign out_from_side = side_r;
  assign out_discard   = discard_r;
  assign out_finished  = fin_r;
  assign out_key       = key_r;
  assign out_seq       = seq_r;
  assign out_kind      = kind_r;
  assign out_next_side = next_r;

endmodule

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mtskdv_pkg::*;

  // one expected merge output
  typedef struct packed {
    logic              side;
    logic              discard;
    logic              finished;
    logic [KEY_W-1:0]  key;
    logic [SEQ_W-1:0]  seq;
    logic [KIND_W-1:0] kind;
    logic [1:0]        next_side;
  } merged_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_source_port = 1'b0;
  logic [63:0] in_item_key = '0;
  logic [55:0] in_item_seq = '0;
  logic [7:0]  in_item_kind = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_from_side;
  logic        out_discard;
  logic        out_finished;
  logic [63:0] out_key;
  logic [55:0] out_seq;
  logic [7:0]  out_kind;
  logic [1:0]  out_next_side;

  merge_two_sorted_keys_drop_versions u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_source_port (in_source_port),
    .in_item_key    (in_item_key),
    .in_item_seq    (in_item_seq),
    .in_item_kind   (in_item_kind),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_from_side  (out_from_side),
    .out_discard    (out_discard),
    .out_finished   (out_finished),
    .out_key        (out_key),
    .out_seq        (out_seq),
    .out_kind       (out_kind),
    .out_next_side  (out_next_side)
  );

  // merge state as the bench sees it, updated on every accepted request
  logic [KEY_W-1:0]  head_key  [2];
  logic [SEQ_W-1:0]  head_seq  [2];
  logic [KIND_W-1:0] head_kind [2];
  bit                head_held [2];
  bit                side_ended [2];
  logic [KEY_W-1:0]  run_key = KEY_ONES;
  logic [SEQ_W-1:0]  run_seq = SEQ_ONES;
  bit                merge_done = 1'b0;
  logic [SNAP_W-1:0] snapshot_floor = '0;

  merged_entry_t expected_entries[$];
  int unsigned   mismatch_count = 0;
  bit            steady_flow = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #6_000_000;
    $display("Mismatches found");
    $finish;
  end

  // mostly back to back, sometimes a short pause, rarely a long one
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns  %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // apply one accepted request to the merge state and queue the output it causes
  task automatic predict_request(input logic side, input logic [63:0] k,
                                 input logic [55:0] s, input logic [7:0] t);
    merged_entry_t e;
    logic          pick;
    // requests for a side that still holds a head or has ended are dropped,
    // and so is everything once the merge is complete
    if (merge_done || head_held[side] || side_ended[side]) return;
    // all-zero key, sequence and kind mark the end of a side
    if (k == '0 && s == '0 && t == '0) begin
      side_ended[side] = 1'b1;
    end else begin
      head_key[side]  = k;
      head_seq[side]  = s;
      head_kind[side] = t;
      head_held[side] = 1'b1;
    end
    // nothing to choose until both sides are resolved
    if (!(head_held[0] || side_ended[0]) || !(head_held[1] || side_ended[1])) return;
    if (!head_held[0] && !head_held[1]) begin
      merge_done = 1'b1;
      e = '{side: 1'b0, discard: 1'b0, finished: 1'b1, key: '0, seq: '0, kind: '0,
            next_side: SIDE_NONE};
      expected_entries.push_back(e);
      return;
    end
    // smaller user key first, then larger sequence, full tie to side 0
    if (head_held[0] && head_held[1]) begin
      if (head_key[0] != head_key[1]) pick = (head_key[0] > head_key[1]);
      else pick = (head_seq[0] < head_seq[1]);
    end else begin
      pick = head_held[1];
    end
    head_held[pick] = 1'b0;
    e.side      = pick;
    e.finished  = 1'b0;
    e.key       = head_key[pick];
    e.seq       = head_seq[pick];
    e.kind      = head_kind[pick];
    e.next_side = {1'b0, pick};
    // a new user key restarts the version run
    if (e.key != run_key) begin
      run_key = e.key;
      run_seq = SEQ_ONES;
    end
    // older version shadowed by one at or below the floor, or a dead deletion
    e.discard = (64'(run_seq) <= snapshot_floor) ||
                (e.kind == KIND_DELETION && 64'(e.seq) <= snapshot_floor);
    run_seq = e.seq;
    expected_entries.push_back(e);
  endtask

  // side the merge is waiting on; random when both are needed
  function automatic logic side_wanted();
    bit need0, need1;
    need0 = !head_held[0] && !side_ended[0];
    need1 = !head_held[1] && !side_ended[1];
    if (need0 && need1) return 1'($urandom_range(0, 1));
    return !need0;
  endfunction

  // present one request, hold it until accepted, then maybe pause
  task automatic send_request(input logic side, input logic [63:0] k,
                              input logic [55:0] s, input logic [7:0] t);
    int unsigned gap;
    in_valid       <= 1'b1;
    in_source_port <= side;
    in_item_key    <= k;
    in_item_seq    <= s;
    in_item_kind   <= t;
    do @(posedge clk); while (!in_ready);
    predict_request(side, k, s, t);
    gap = steady_flow ? 0 : gap_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // floor changes only while the block is idle
  task automatic write_snapshot(input logic [63:0] value);
    in_valid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    // a request without output may still be in the front stage
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    snapshot_floor = value;
  endtask

  function automatic logic [7:0] random_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return KIND_DELETION;
    if (r < 90) return 8'd1;
    return 8'($urandom);
  endfunction

  // sequence for a fresh user key, mostly straddling the floor
  function automatic logic [55:0] fresh_seq(input logic [63:0] floor_value);
    longint      v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      v = (floor_value > 64'(SEQ_ONES)) ? longint'(SEQ_ONES) : longint'(floor_value);
      v = v + $urandom_range(0, 6) - 3;
      if (v < 0) v = 0;
      if (v > longint'(SEQ_ONES)) v = longint'(SEQ_ONES);
      return 56'(v);
    end
    if (r < 70) return 56'($urandom_range(0, 4));
    if (r < 80) return SEQ_ONES - 56'($urandom_range(0, 4));
    return 56'({$urandom, $urandom});
  endfunction

  // start of merge, tie breaks, both drop rules and the field extremes
  task automatic test_directed_corners();
    send_request(1'b0, 64'd5, 56'd100, 8'd1);         // first key alone, no output
    send_request(1'b0, 64'd6, 56'd1, 8'd1);           // head 0 still held, ignored
    send_request(1'b1, 64'd5, 56'd100, KIND_DELETION); // full tie goes to side 0
    send_request(1'b0, 64'd5, 56'd100, 8'hff);
    send_request(1'b0, 64'd5, 56'd0, KIND_DELETION);  // side 1 wins on larger seq
    send_request(1'b1, 64'd5, 56'd0, 8'd1);           // deletion at the floor
    send_request(1'b0, 64'd0, 56'd1, 8'd1);           // zero user key, not an end mark
    send_request(1'b0, KEY_ONES, SEQ_ONES, 8'hff);
    send_request(1'b1, 64'd5, 56'd0, 8'd1);           // shadowed older version
    send_request(1'b1, KEY_ONES, 56'd0, 8'd1);
    send_request(1'b0, KEY_ONES, 56'd0, KIND_DELETION);
    send_request(1'b0, 64'd0, 56'd0, 8'd1);
    send_request(1'b0, 64'd0, 56'd5, KIND_DELETION);
  endtask

  // sorted streams per side with random content, plus some noise
  task automatic test_random_merge(input int n, input logic [63:0] floor_value,
                                   input bit steady);
    logic [63:0] cur_key [2];
    logic [55:0] cur_seq [2];
    logic [63:0] k;
    logic [55:0] s;
    logic [7:0]  t;
    logic        side;
    int          sent;
    int unsigned r;
    write_snapshot(floor_value);
    steady_flow = steady;
    cur_key[0] = {$urandom, $urandom};
    if (cur_key[0] > 64'hffff_ffff_ffff_0000) cur_key[0] = cur_key[0] - 64'h1_0000;
    cur_key[1] = cur_key[0];
    cur_seq[0] = fresh_seq(floor_value);
    cur_seq[1] = fresh_seq(floor_value);
    sent = 0;
    while (sent < n) begin
      r    = $urandom_range(0, 99);
      side = side_wanted();
      if (r < 6) begin
        // request for the side that is not waited on
        send_request(!side, {$urandom, $urandom}, 56'({$urandom, $urandom}), 8'd1);
        continue;
      end
      if (r < 14) begin
        k = {$urandom, $urandom};
        s = 56'({$urandom, $urandom});
        t = 8'($urandom);
      end else begin
        if ($urandom_range(0, 9) < 4 && cur_seq[side] > 56'd3) begin
          // older version of the same user key
          cur_seq[side] = cur_seq[side] - 56'($urandom_range(1, 3));
        end else begin
          cur_key[side] = cur_key[side] + 64'($urandom_range(1, 2));
          cur_seq[side] = fresh_seq(floor_value);
        end
        k = cur_key[side];
        s = cur_seq[side];
        t = random_kind();
      end
      if (k == '0 && s == '0 && t == '0) t = 8'd1;
      send_request(side, k, s, t);
      sent++;
    end
  endtask

  // end one side, run the other alone, end it, then poke the finished block
  task automatic test_end_of_sides();
    logic        first_end;
    logic [63:0] base;
    write_snapshot(64'd1000);
    steady_flow = 1'b0;
    first_end = side_wanted();
    send_request(first_end, '0, '0, '0);
    base = {1'b0, 31'($urandom), $urandom};
    for (int i = 0; i < 20; i++) begin
      send_request(!first_end, base + 64'(i / 2), fresh_seq(64'd1000), random_kind());
      if (i == 10) send_request(first_end, base, 56'd7, 8'd1);  // side already ended
    end
    send_request(!first_end, '0, '0, '0);
    for (int i = 0; i < 3; i++) begin
      send_request(1'($urandom), {$urandom, $urandom}, 56'($urandom), 8'd1);
    end
    in_valid <= 1'b0;
  endtask

  // result stall pattern follows the same gap mix unless the phase runs steady
  initial begin
    int unsigned stall;
    forever begin
      @(posedge clk);
      stall = steady_flow ? 0 : gap_cycles();
      if (stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    merged_entry_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_entries.size() == 0) begin
        report_mismatch("unexpected result, key", out_key, '0);
      end else begin
        want = expected_entries.pop_front();
        if (out_from_side !== want.side)
          report_mismatch("from_side", 64'(out_from_side), 64'(want.side));
        if (out_discard !== want.discard)
          report_mismatch("discard", 64'(out_discard), 64'(want.discard));
        if (out_finished !== want.finished)
          report_mismatch("finished", 64'(out_finished), 64'(want.finished));
        if (out_key !== want.key)
          report_mismatch("key", out_key, want.key);
        if (out_seq !== want.seq)
          report_mismatch("seq", 64'(out_seq), 64'(want.seq));
        if (out_kind !== want.kind)
          report_mismatch("kind", 64'(out_kind), 64'(want.kind));
        if (out_next_side !== want.next_side)
          report_mismatch("next_side", 64'(out_next_side), 64'(want.next_side));
      end
    end
  end

  initial begin
    head_held  = '{1'b0, 1'b0};
    side_ended = '{1'b0, 1'b0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    // one long merge, floor moved between phases while idle
    test_random_merge(200, 64'd5, 1'b0);
    test_random_merge(200, 64'(SEQ_ONES) - 64'd1, 1'b0);
    test_random_merge(200, 64'(SEQ_ONES), 1'b1);
    test_random_merge(200, '1, 1'b0);
    test_random_merge(200, 64'(56'({$urandom, $urandom})), 1'b0);
    test_random_merge(200, '0, 1'b1);
    test_random_merge(200, {$urandom, $urandom}, 1'b0);
    test_end_of_sides();

    while (expected_entries.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
